@@ rtl/core/aipr_pkg.sv @@
// Shared types and constants for the address identifier port registry.
package aipr_pkg;

  // Request field widths
  localparam int unsigned ADDR_ID_W = 8;
  localparam int unsigned IP_W      = 32;
  localparam int unsigned PORT_W    = 16;
  localparam int unsigned IN_DATA_W = 56;  // addr_id, ip_addr, port; whole bytes
  localparam int unsigned OUT_DATA_W = 8;  // accepted, status, zero fill

  // Request kinds (carried on tuser)
  localparam logic KIND_ADD    = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_OTHER_ADDR = 3'd1,
    STAT_DUP_PORT   = 3'd2,
    STAT_ABSENT     = 3'd3,
    STAT_FULL       = 3'd4
  } status_t;

endpackage

@@ rtl/core/aipr_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
module aipr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/address_id_port_registry.sv @@
// Top level: identifier-indexed address and port table with a scan sequencer.
//
//  channel | ports                         | payload
//  --------+-------------------------------+------------------------------------------
//  in      | in_tvalid/in_tready           | tuser: kind; tdata: addr_id, ip_addr, port
//  out     | out_tvalid/out_tready         | tdata: accepted, status
//
// One request at a time. Remove, out-of-range ids, new entries, address
// mismatches and port-zero adds go from the entry lookup straight to the
// result; an add of a nonzero port to a bound entry first scans its list (one
// RAM read and one compare per listed port, through the port list memory's
// single read port), ending early when a duplicate is found.
// Reset clears the valid bits at once; no clearing pass. The result register
// lets a new request be taken while the last result waits; a finished request
// holds in the response state until that register is free.
module address_id_port_registry
  import aipr_pkg::*;
#(
  parameter int unsigned ID_COUNT  = 256,
  parameter int unsigned MAX_PORTS = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] addr_id, [39:8] ip_addr, [55:40] port
  input  logic                  in_tuser,   // [0] kind
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // [0] accepted, [3:1] status, [7:4] zero
);

  localparam int unsigned ID_W    = $clog2(ID_COUNT);
  localparam int unsigned CNT_W   = $clog2(MAX_PORTS + 1);
  localparam int unsigned SLOT_W  = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1;
  localparam int unsigned META_W  = IP_W + CNT_W;
  localparam int unsigned PL_DEPTH = ID_COUNT << SLOT_W;
  localparam logic [ADDR_ID_W:0] ID_LIMIT = (ADDR_ID_W + 1)'(ID_COUNT);
  localparam logic [CNT_W-1:0]   CNT_MAX  = CNT_W'(MAX_PORTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_META,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_APPEND,
    S_RESP
  } state_t;

  // Unpacked request fields
  logic [ADDR_ID_W-1:0] in_addr_id;
  logic [IP_W-1:0]      in_ip_addr;
  logic [PORT_W-1:0]    in_port;
  logic                 in_fire;

  assign in_addr_id = in_tdata[ADDR_ID_W-1:0];
  assign in_ip_addr = in_tdata[ADDR_ID_W +: IP_W];
  assign in_port    = in_tdata[ADDR_ID_W + IP_W +: PORT_W];
  assign in_fire    = in_tvalid & in_tready;

  // Registers
  state_t            state_r, state_nxt;
  logic [ID_COUNT-1:0] valid_r, valid_nxt;
  logic              kind_r;
  logic              in_range_r;
  logic [ID_W-1:0]   id_r;
  logic [IP_W-1:0]   ip_r;
  logic [PORT_W-1:0] port_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  status_t           status_r, status_nxt;
  logic              out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // Memory ports
  logic              meta_we;
  logic [META_W-1:0] meta_wdata;
  logic [META_W-1:0] meta_rdata;
  logic              pl_we;
  logic [SLOT_W-1:0] pl_wslot;
  logic              pl_re;
  logic [PORT_W-1:0] pl_rdata;

  logic [IP_W-1:0]   meta_ip;
  logic [CNT_W-1:0]  meta_cnt;
  logic              resp_load;

  assign meta_ip   = meta_rdata[IP_W-1:0];
  assign meta_cnt  = meta_rdata[IP_W +: CNT_W];
  assign in_tready = (state_r == S_IDLE);
  assign pl_re     = (state_r == S_SCAN_RD);
  assign resp_load = (state_r == S_RESP) && (!out_valid_r || out_tready);

  // Entry address and port count, read on acceptance
  aipr_ram #(
    .WIDTH (META_W),
    .DEPTH (ID_COUNT)
  ) u_meta_ram (
    .clk     (clk),
    .wr_en   (meta_we),
    .wr_addr (id_r),
    .wr_data (meta_wdata),
    .rd_en   (in_fire),
    .rd_addr (in_addr_id[ID_W-1:0]),
    .rd_data (meta_rdata)
  );

  // Port lists, one row of slots per identifier
  aipr_ram #(
    .WIDTH (PORT_W),
    .DEPTH (PL_DEPTH)
  ) u_port_ram (
    .clk     (clk),
    .wr_en   (pl_we),
    .wr_addr ({id_r, pl_wslot}),
    .wr_data (port_r),
    .rd_en   (pl_re),
    .rd_addr ({id_r, k_r[SLOT_W-1:0]}),
    .rd_data (pl_rdata)
  );

  // Sequencer next state and memory writes
  always_comb begin
    state_nxt  = state_r;
    valid_nxt  = valid_r;
    cnt_nxt    = cnt_r;
    k_nxt      = k_r;
    status_nxt = status_r;
    meta_we    = 1'b0;
    meta_wdata = {cnt_r, ip_r};
    pl_we      = 1'b0;
    pl_wslot   = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_META;
        end
      end
      S_META: begin
        state_nxt = S_RESP;
        priority if (!in_range_r) begin
          status_nxt = STAT_ABSENT;
        end else if (kind_r == KIND_REMOVE) begin
          if (valid_r[id_r]) begin
            valid_nxt[id_r] = 1'b0;
            status_nxt      = STAT_OK;
          end else begin
            status_nxt = STAT_ABSENT;
          end
        end else if (!valid_r[id_r]) begin
          // new entry, keeps its port if one is given
          valid_nxt[id_r] = 1'b1;
          meta_we         = 1'b1;
          meta_wdata      = {((port_r != '0) ? CNT_W'(1) : CNT_W'(0)), ip_r};
          pl_we           = (port_r != '0);
          status_nxt      = STAT_OK;
        end else if (meta_ip != ip_r) begin
          status_nxt = STAT_OTHER_ADDR;
        end else if (port_r == '0) begin
          status_nxt = STAT_OK;
        end else begin
          cnt_nxt   = meta_cnt;
          k_nxt     = '0;
          state_nxt = (meta_cnt == '0) ? S_APPEND : S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        state_nxt = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        priority if (pl_rdata == port_r) begin
          status_nxt = STAT_DUP_PORT;
          state_nxt  = S_RESP;
        end else if (CNT_W'(k_r + 1'b1) == cnt_r) begin
          state_nxt = S_APPEND;
        end else begin
          k_nxt     = CNT_W'(k_r + 1'b1);
          state_nxt = S_SCAN_RD;
        end
      end
      S_APPEND: begin
        state_nxt = S_RESP;
        if (cnt_r >= CNT_MAX) begin
          status_nxt = STAT_FULL;
        end else begin
          pl_we      = 1'b1;
          pl_wslot   = cnt_r[SLOT_W-1:0];
          meta_we    = 1'b1;
          meta_wdata = {CNT_W'(cnt_r + 1'b1), ip_r};
          status_nxt = STAT_OK;
        end
      end
      S_RESP: begin
        if (resp_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, valid bits and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      if (resp_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request capture and datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r     <= in_tuser;
      in_range_r <= ({1'b0, in_addr_id} < ID_LIMIT);
      id_r       <= in_addr_id[ID_W-1:0];
      ip_r       <= in_ip_addr;
      port_r     <= in_port;
    end
    cnt_r    <= cnt_nxt;
    k_r      <= k_nxt;
    status_r <= status_nxt;
    if (resp_load) begin
      out_data_r <= {4'b0000, status_r, (status_r == STAT_OK)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  // Scan never reads past the listed ports
  a_scan_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN_CMP) |-> (k_r < cnt_r))
    else $error("port scan index beyond list length");

  // Stored count never exceeds list capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    meta_we |-> (meta_wdata[IP_W +: CNT_W] <= CNT_MAX))
    else $error("port count written above capacity");

  // Accepted flag agrees with status
  a_accept_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tdata[3:1] == STAT_OK)))
    else $error("accepted flag disagrees with status");

  // A successful remove frees the entry
  a_remove_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_META && in_range_r && kind_r == KIND_REMOVE) |=> !valid_r[$past(id_r)])
    else $error("removed entry still valid");

  // Port list is written only while creating or appending
  a_pl_write: assert property (@(posedge clk) disable iff (!rst_n)
    pl_we |-> (state_r == S_META || state_r == S_APPEND))
    else $error("port list written outside create or append");
`endif

endmodule

@@ bench/tb.sv @@
// Self-checking bench for the address identifier port registry: directed and random requests.
module tb
  import aipr_pkg::*;
();

  localparam int unsigned TABLE_IDS   = 256;
  localparam int unsigned LIST_DEPTH  = 4;
  localparam int unsigned POOL_SIZE   = 6;
  localparam int unsigned DRAIN_WAIT  = 30;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic    accepted;
    status_t status;
  } registry_result_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;  // [7:0] addr_id, [39:8] ip_addr, [55:40] port
  logic                  in_tuser   = KIND_ADD;  // [0] kind
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;  // [0] accepted, [3:1] status, [7:4] zero

  // Shadow copy of the table
  logic        id_bound     [TABLE_IDS];
  logic [31:0] bound_ip     [TABLE_IDS];
  int unsigned listed_count [TABLE_IDS];
  logic [15:0] listed_port  [TABLE_IDS][LIST_DEPTH];

  registry_result_t pending_results[$];
  int unsigned      mismatch_count = 0;
  int unsigned      cycle_count    = 0;
  logic             idle_on        = 1'b0;
  int unsigned      stall_left     = 0;

  // Traffic pools for the random phases
  logic [7:0]  pool_id   [POOL_SIZE];
  logic [15:0] pool_port [POOL_SIZE];
  logic [31:0] home_ip   [TABLE_IDS];

  address_id_port_registry u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side backpressure: random stall bursts while idle_on is set
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 11);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each result with the oldest prediction
  always @(posedge clk) begin
    registry_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result: accepted=%0d status=%0d",
                   out_tdata[0], out_tdata[3:1]);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[0] !== want.accepted || out_tdata[3:1] !== want.status) begin
          if (mismatch_count < 10)
            $display("result mismatch: expected accepted=%0d status=%0d, %s%0d status=%0d",
                     want.accepted, want.status, "got accepted=",
                     out_tdata[0], out_tdata[3:1]);
          mismatch_count++;
        end
      end
    end
  end

  // Apply one request to the shadow table and return its status
  function automatic status_t apply_request(logic kind, logic [7:0] id, logic [31:0] ip,
                                            logic [15:0] port);
    int unsigned n;
    if (kind == KIND_REMOVE) begin
      if (!id_bound[id]) return STAT_ABSENT;
      id_bound[id] = 1'b0;
      return STAT_OK;
    end
    // free id: create, keeping a nonzero port
    if (!id_bound[id]) begin
      id_bound[id]     = 1'b1;
      bound_ip[id]     = ip;
      listed_count[id] = 0;
      if (port != '0) begin
        listed_port[id][0] = port;
        listed_count[id]   = 1;
      end
      return STAT_OK;
    end
    if (bound_ip[id] != ip) return STAT_OTHER_ADDR;
    if (port == '0) return STAT_OK;
    n = listed_count[id];
    for (int k = 0; k < n; k++)
      if (listed_port[id][k] == port) return STAT_DUP_PORT;
    if (n >= LIST_DEPTH) return STAT_FULL;
    listed_port[id][n] = port;
    listed_count[id]   = n + 1;
    return STAT_OK;
  endfunction

  // Send one request; valid stays high on return so a back-to-back request keeps it up
  task automatic send_request(logic kind, logic [7:0] id, logic [31:0] ip, logic [15:0] port);
    registry_result_t want;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {port, ip, id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    want.status   = apply_request(kind, id, ip, port);
    want.accepted = (want.status == STAT_OK);
    pending_results = {pending_results, want};
  endtask

  // Stop sending and wait for every outstanding result
  task automatic wait_until_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Absent removes, new entries, address conflicts and port-zero adds
  task automatic test_absent_and_new();
    send_request(KIND_REMOVE, 8'h00, 32'h0, 16'h0);
    send_request(KIND_ADD, 8'h00, 32'h0, 16'h0);
    send_request(KIND_ADD, 8'h00, 32'h0, 16'h0);
    send_request(KIND_ADD, 8'h00, 32'h1, 16'h5);
    send_request(KIND_ADD, 8'h00, 32'h0, 16'h9);
    send_request(KIND_REMOVE, 8'h00, 32'hffff_ffff, 16'hffff);
    send_request(KIND_REMOVE, 8'h00, 32'h0, 16'h0);
  endtask

  // Duplicate ports and a list run up to full
  task automatic test_port_list_limits();
    send_request(KIND_ADD, 8'hff, 32'hffff_ffff, 16'hffff);
    send_request(KIND_ADD, 8'hff, 32'hffff_ffff, 16'hffff);
    send_request(KIND_ADD, 8'hff, 32'hffff_ffff, 16'h0001);
    send_request(KIND_ADD, 8'hff, 32'hffff_ffff, 16'h8000);
    send_request(KIND_ADD, 8'hff, 32'hffff_ffff, 16'h0002);
    send_request(KIND_ADD, 8'hff, 32'hffff_ffff, 16'h0003);
    send_request(KIND_ADD, 8'hff, 32'hffff_ffff, 16'h0001);
    send_request(KIND_ADD, 8'hff, 32'hffff_ffff, 16'h0000);
    send_request(KIND_ADD, 8'hff, 32'h7fff_ffff, 16'h0004);
    send_request(KIND_REMOVE, 8'hff, 32'h0, 16'h0);
    send_request(KIND_REMOVE, 8'hff, 32'h0, 16'h0);
    send_request(KIND_ADD, 8'hff, 32'h1234_5678, 16'h0007);
    send_request(KIND_ADD, 8'hff, 32'h1234_5678, 16'h0003);
  endtask

  // Well-formed traffic on a few ids so lists fill, collide and get removed
  task automatic test_pool_traffic(int unsigned count);
    logic [7:0]  id;
    logic [31:0] ip;
    logic [15:0] port;
    int unsigned pick;
    for (int i = 0; i < count; i++) begin
      id   = pool_id[$urandom_range(0, POOL_SIZE - 1)];
      pick = $urandom_range(0, 99);
      ip   = home_ip[id];
      port = ($urandom_range(0, 9) == 0) ? 16'h0 : pool_port[$urandom_range(0, POOL_SIZE - 1)];
      if (pick < 8) begin
        send_request(KIND_REMOVE, id, $urandom, 16'($urandom));
        if ($urandom_range(0, 1) == 1) home_ip[id] = $urandom;
      end else begin
        if (pick < 18) ip = ip ^ ($urandom | 32'h1);
        send_request(KIND_ADD, id, ip, port);
      end
      // now and then let everything drain before going on
      if (i % 150 == 149) wait_until_drained();
    end
  endtask

  // Unconstrained fields across the whole table
  task automatic test_wide_noise(int unsigned count);
    for (int i = 0; i < count; i++)
      send_request(logic'($urandom_range(0, 1)), 8'($urandom), $urandom, 16'($urandom));
  endtask

  initial begin
    for (int i = 0; i < TABLE_IDS; i++) begin
      id_bound[i] = 1'b0;
      home_ip[i]  = $urandom;
    end
    pool_id[0] = 8'h00;
    pool_id[1] = 8'hff;
    for (int i = 2; i < POOL_SIZE; i++) pool_id[i] = 8'($urandom);
    for (int i = 0; i < POOL_SIZE; i++) pool_port[i] = 16'($urandom_range(1, 65535));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_absent_and_new();
    test_port_list_limits();
    wait_until_drained();

    idle_on <= 1'b1;
    test_pool_traffic(700);
    test_wide_noise(150);
    wait_until_drained();

    // closing stretch without idling on either side
    idle_on <= 1'b0;
    test_pool_traffic(250);

    wait_until_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
